// ----- rtl/nm3x3_pkg.sv -----
// shared constants, types and helper functions of the 3x3 neighbor mean filter
`default_nettype none

package nm3x3_pkg;

    // frame geometry
    localparam int SIDE  = 256;
    localparam int COL_W = (SIDE > 2) ? $clog2(SIDE) : 1;
    // input row runs up to side + 1 while the frame drains
    localparam int ROW_W = $clog2(SIDE + 2);

    // data widths
    localparam int PIX_W  = 16;
    localparam int SUM_W  = PIX_W + 3;
    localparam int MEAN_W = 24;
    localparam int CNT_W  = 4;

    // input word kinds carried on tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // rounded divide: q = floor((512 * mag + n) / (2 * n)) through a reciprocal
    localparam int RECIP_SH = 29;
    localparam int X_W      = SUM_W + 10;
    localparam int REC_W    = 27;
    localparam int MUL_W    = X_W + REC_W;
    localparam int Q_W      = 27;
    localparam int DEN_W    = 5;

    // neighbor counts
    localparam logic [CNT_W-1:0] CNT_CORNER = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_EDGE   = CNT_W'(5);
    localparam logic [CNT_W-1:0] CNT_INNER  = CNT_W'(8);

    localparam logic [REC_W-1:0] REC_CORNER = REC_W'((2 ** RECIP_SH) / 6);
    localparam logic [REC_W-1:0] REC_EDGE   = REC_W'((2 ** RECIP_SH) / 10);
    localparam logic [REC_W-1:0] REC_INNER  = REC_W'((2 ** RECIP_SH) / 16);

    // where the center pixel sits against the frame border
    typedef struct packed {
        logic top;
        logic bot;
        logic lft;
        logic rgt;
        logic last;
    } t_pos_flags;

    function automatic logic [CNT_W-1:0] count_of(input t_pos_flags f);
        logic [1:0] vert;
        logic [1:0] horz;
        logic [CNT_W-1:0] cnt;
        vert = 2'(f.top) + 2'(f.bot);
        horz = 2'(f.lft) + 2'(f.rgt);
        if (vert == 2'd2 && horz == 2'd2) begin
            cnt = CNT_INNER;
        end else if (vert == 2'd2 || horz == 2'd2) begin
            cnt = CNT_EDGE;
        end else begin
            cnt = CNT_CORNER;
        end
        return cnt;
    endfunction

    function automatic logic [REC_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [REC_W-1:0] rec;
        unique case (cnt)
            CNT_CORNER: rec = REC_CORNER;
            CNT_EDGE:   rec = REC_EDGE;
            CNT_INNER:  rec = REC_INNER;
            default:    rec = '0;
        endcase
        return rec;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nm3x3_ram.sv -----
// generic simple dual port ram with registered read
`default_nettype none

module nm3x3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [(DEPTH > 2 ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic                                        i_re,
    input  wire logic [(DEPTH > 2 ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/neighbor_mean_3x3.sv -----
// top level of the streaming 3x3 neighbor mean filter
//
//  channel  | dir | handshake                     | contents
//  ---------+-----+-------------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: pixel, tuser: mode (1 = flush)
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: mean, neighbor_count; tlast
//
//  one word is taken per clock unless the output stalls; the word that completes a result carries it
//  through the five register stages (row store read, window, sum, reciprocal multiply, correction),
//  which move together; a stalled output word freezes all of them and drops s_axis_tready
//  synchronous active low reset clears counters and valid bits; row stores are not cleared
//  a frame needs side + 1 flush words after its last pixel to drain every result
`default_nettype none

module neighbor_mean_3x3
    import nm3x3_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] pixel (signed)
    input  wire logic        s_axis_tuser,   // [0] mode: 0 pixel, 1 flush
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [23:0] mean (signed, 8 frac), [27:24] count
    output logic             m_axis_tlast    // frame_last
);

    // pipeline advance: everything moves unless a result waits at the output
    logic en;
    logic accept;

    // position counters
    logic [ROW_W-1:0] r_in_row, n_in_row;
    logic [COL_W-1:0] r_in_col, n_in_col;
    logic [COL_W-1:0] r_out_row, n_out_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic             emit;
    t_pos_flags       pos;

    // stage 1: row store read in flight
    logic             r_v1;
    logic             r_emit1;
    t_pos_flags       r_pos1;
    logic [PIX_W-1:0] r_p1;
    logic [COL_W-1:0] r_col1;
    logic [PIX_W-1:0] up_rdata;
    logic [PIX_W-1:0] mid_rdata;

    // stage 2: window
    logic             r_v2;
    logic             r_emit2;
    t_pos_flags       r_pos2;
    logic [PIX_W-1:0] r_win [9];

    // stage 3: masked sum
    logic                    r_v3;
    logic signed [SUM_W-1:0] r_sum3;
    logic [CNT_W-1:0]        r_cnt3;
    logic                    r_last3;
    logic signed [SUM_W-1:0] sum2;
    logic [8:0]              use2;

    // stage 4: reciprocal product
    logic             r_v4;
    logic [MUL_W-1:0] r_prod4;
    logic [X_W-1:0]   r_x4;
    logic [DEN_W-1:0] r_den4;
    logic             r_neg4;
    logic [CNT_W-1:0] r_cnt4;
    logic             r_last4;
    logic [SUM_W-1:0] mag3;
    logic [X_W-1:0]   x3;

    // output stage
    logic              r_out_valid;
    logic [MEAN_W-1:0] r_mean;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_last;
    logic [Q_W-1:0]    q0;
    logic [X_W-1:0]    rem;
    logic [Q_W-1:0]    q;
    logic [Q_W-1:0]    q_signed;

    assign en            = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && en;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // position tracking at accept time
    // ------------------------------------------------------------------
    assign emit = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && r_in_col != '0);

    always_comb begin
        pos.top  = r_out_row != '0;
        pos.bot  = r_out_row != COL_W'(SIDE - 1);
        pos.lft  = r_out_col != '0;
        pos.rgt  = r_out_col != COL_W'(SIDE - 1);
        pos.last = !pos.bot && !pos.rgt;
    end

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (accept) begin
            if (r_in_col == COL_W'(SIDE - 1)) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
            if (emit) begin
                if (r_out_col == COL_W'(SIDE - 1)) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + COL_W'(1);
                end else begin
                    n_out_col = r_out_col + COL_W'(1);
                end
                // frame done: every position goes back to the origin
                if (pos.last) begin
                    n_in_row  = '0;
                    n_in_col  = '0;
                    n_out_row = '0;
                    n_out_col = '0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // row stores: upper holds two rows up, middle one row up
    // ------------------------------------------------------------------
    nm3x3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SIDE)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (en && r_v1),
        .i_waddr (r_col1),
        .i_wdata (mid_rdata),
        .i_re    (accept),
        .i_raddr (r_in_col),
        .o_rdata (up_rdata)
    );

    nm3x3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (SIDE)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (en && r_v1),
        .i_waddr (r_col1),
        .i_wdata (r_p1),
        .i_re    (accept),
        .i_raddr (r_in_col),
        .o_rdata (mid_rdata)
    );

    // ------------------------------------------------------------------
    // masked neighbor sum over the window, center left out
    // ------------------------------------------------------------------
    always_comb begin
        use2[0] = r_pos2.top && r_pos2.lft;
        use2[1] = r_pos2.top;
        use2[2] = r_pos2.top && r_pos2.rgt;
        use2[3] = r_pos2.lft;
        use2[4] = 1'b0;
        use2[5] = r_pos2.rgt;
        use2[6] = r_pos2.bot && r_pos2.lft;
        use2[7] = r_pos2.bot;
        use2[8] = r_pos2.bot && r_pos2.rgt;
    end

    always_comb begin
        sum2 = '0;
        for (int k = 0; k < 9; k++) begin
            if (use2[k]) begin
                sum2 = sum2 + SUM_W'(signed'(r_win[k]));
            end
        end
    end

    // ------------------------------------------------------------------
    // rounded divide, magnitude first: x = 512 * |sum| + n over 2n
    // ------------------------------------------------------------------
    assign mag3 = r_sum3[SUM_W-1] ? SUM_W'(-r_sum3) : SUM_W'(r_sum3);
    assign x3   = (X_W'(mag3) << 9) + X_W'(r_cnt3);

    // reciprocal quotient is exact or one short; one compare fixes it
    assign q0       = r_prod4[RECIP_SH +: Q_W];
    assign rem      = r_x4 - X_W'(q0) * X_W'(r_den4);
    assign q        = (rem >= X_W'(r_den4)) ? q0 + Q_W'(1) : q0;
    assign q_signed = r_neg4 ? Q_W'(-q) : q;

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row    <= '0;
            r_in_col    <= '0;
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            if (en) begin
                r_v1        <= accept;
                r_v2        <= r_v1;
                r_v3        <= r_v2 && r_emit2;
                r_v4        <= r_v3;
                r_out_valid <= r_v4;
                // window shifts left; the new column enters on the right
                if (r_v1) begin
                    for (int r = 0; r < 3; r++) begin
                        r_win[r*3]     <= r_win[r*3 + 1];
                        r_win[r*3 + 1] <= r_win[r*3 + 2];
                    end
                    r_win[2] <= up_rdata;
                    r_win[5] <= mid_rdata;
                    r_win[8] <= r_p1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: a flush word acts as a zero pixel
            r_p1    <= (s_axis_tuser == MODE_FLUSH) ? '0 : s_axis_tdata;
            r_col1  <= r_in_col;
            r_emit1 <= emit;
            r_pos1  <= pos;
            // stage 2
            r_emit2 <= r_emit1;
            r_pos2  <= r_pos1;
            // stage 3
            r_sum3  <= sum2;
            r_cnt3  <= count_of(r_pos2);
            r_last3 <= r_pos2.last;
            // stage 4
            r_prod4 <= MUL_W'(x3) * MUL_W'(recip_of(r_cnt3));
            r_x4    <= x3;
            r_den4  <= DEN_W'({r_cnt3, 1'b0});
            r_neg4  <= r_sum3[SUM_W-1];
            r_cnt4  <= r_cnt3;
            r_last4 <= r_last3;
            // output
            r_mean  <= q_signed[MEAN_W-1:0];
            r_cnt   <= r_cnt4;
            r_last  <= r_last4;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_cnt, r_mean};
    assign m_axis_tlast  = r_last;

endmodule

`default_nettype wire

// ----- tb/neighbor_mean_3x3_tb.sv -----
// self-checking testbench of the streaming 3x3 neighbor mean filter
`timescale 1ns / 1ps

module neighbor_mean_3x3_tb;
    import nm3x3_pkg::*;

    localparam logic [PIX_W-1:0] PIX_MAX = 16'h7fff;
    localparam logic [PIX_W-1:0] PIX_MIN = 16'h8000;

    localparam int PIPE_DEPTH   = 5;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int LONG_HOLD    = 500;
    localparam int HOLDS        = 3;
    localparam int DIRECTED_N   = 20;
    localparam int FIRST_PART   = 500;
    localparam int SECOND_PART  = 530;
    localparam int MAX_PRINTS   = 40;

    typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} t_pace;
    typedef enum int {FILL_MIXED, FILL_MAX, FILL_MIN, FILL_CHECKER} t_fill;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [CNT_W-1:0]  count;
        logic              last;
    } t_mean_result;

    // tracks the filter state and the means still owed by the block
    class t_mean_board;
        logic signed [PIX_W-1:0] upper_row [SIDE];
        logic signed [PIX_W-1:0] middle_row [SIDE];
        logic signed [PIX_W-1:0] win [9];
        int unsigned in_row, in_col, out_row, out_col;
        t_mean_result owed_means [$];
        int errors, results_seen, words_in, flush_words;
        int corner_hits, edge_hits, inner_hits, frame_ends;

        function new();
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            foreach (win[i]) win[i] = '0;
            in_row  = 0;
            in_col  = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function int pending();
            return owed_means.size();
        endfunction

        // round(sum * 256 / n), ties away from zero
        function logic [MEAN_W-1:0] rounded_mean(int sum, int n);
            longint mag;
            longint q;
            mag = (sum < 0) ? -longint'(sum) : longint'(sum);
            q = (2 * mag * 256 + n) / (2 * n);
            if (sum < 0) q = -q;
            return q[MEAN_W-1:0];
        endfunction

        // accepted input word: shift the window, maybe owe one mean
        function void note_word(logic mode, logic [PIX_W-1:0] pix);
            logic signed [PIX_W-1:0] p, up, mid;
            int unsigned col_sel;
            bit emit, top, bot, lft, rgt, ok;
            int sum, n;
            t_mean_result res;
            words_in++;
            if (mode == MODE_FLUSH) flush_words++;
            // a flush word inside the frame counts as a zero pixel
            p = (mode == MODE_FLUSH) ? '0 : pix;
            col_sel = (in_col < SIDE) ? in_col : 0;
            up  = upper_row[col_sel];
            mid = middle_row[col_sel];
            upper_row[col_sel]  = mid;
            middle_row[col_sel] = p;
            for (int r = 0; r < 3; r++) begin
                win[r * 3]     = win[r * 3 + 1];
                win[r * 3 + 1] = win[r * 3 + 2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = p;
            // the mean of a pixel is due once its lower-right neighbor is in
            emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= SIDE) begin
                in_col = 0;
                in_row++;
            end
            if (!emit) return;
            top = out_row > 0;
            bot = out_row < SIDE - 1;
            lft = out_col > 0;
            rgt = out_col < SIDE - 1;
            sum = 0;
            n   = 0;
            for (int dr = 0; dr < 3; dr++) begin
                for (int dc = 0; dc < 3; dc++) begin
                    ok = !(dr == 1 && dc == 1);
                    if (dr == 0 && !top) ok = 0;
                    if (dr == 2 && !bot) ok = 0;
                    if (dc == 0 && !lft) ok = 0;
                    if (dc == 2 && !rgt) ok = 0;
                    if (ok) begin
                        sum += win[dr * 3 + dc];
                        n++;
                    end
                end
            end
            res.mean  = rounded_mean(sum, n);
            res.count = CNT_W'(n);
            res.last  = !bot && !rgt;
            owed_means.push_back(res);
            out_col++;
            if (out_col >= SIDE) begin
                out_col = 0;
                out_row++;
            end
            // frame end: every position starts over
            if (res.last) begin
                out_row = 0;
                out_col = 0;
                in_row  = 0;
                in_col  = 0;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
        endtask

        task check_word(logic [31:0] data, logic last);
            t_mean_result want;
            if (owed_means.size() == 0) begin
                report_mismatch($sformatf("word %h last %b with no mean owed", data, last));
                return;
            end
            want = owed_means.pop_front();
            if (data[MEAN_W-1:0] !== want.mean)
                report_mismatch($sformatf("result %0d: mean %h, want %h",
                                          results_seen, data[MEAN_W-1:0], want.mean));
            if (data[27:24] !== want.count)
                report_mismatch($sformatf("result %0d: count %0d, want %0d",
                                          results_seen, data[27:24], want.count));
            if (data[31:28] !== 4'h0)
                report_mismatch($sformatf("result %0d: pad bits %h", results_seen,
                                          data[31:28]));
            if (last !== want.last)
                report_mismatch($sformatf("result %0d: last %b, want %b",
                                          results_seen, last, want.last));
            results_seen++;
            if (want.last) frame_ends++;
            if (want.count == CNT_CORNER) corner_hits++;
            else if (want.count == CNT_EDGE) edge_hits++;
            else inner_hits++;
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [15:0] pixel (signed)
    logic        s_axis_tuser;    // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [23:0] mean, [27:24] count, [31:28] zero
    logic        m_axis_tlast;    // frame_last

    t_mean_board board = new();

    int    cycle_count = 0;
    int    sent_words  = 0;
    t_pace send_pace   = PACE_FULL;
    t_pace sink_pace   = PACE_FULL;
    t_fill row_fill    = FILL_MIXED;
    int    hold_at [HOLDS] = '{150, 450, 700};

    logic             dir_mode [DIRECTED_N] = '{
        MODE_PIXEL, MODE_PIXEL, MODE_PIXEL, MODE_PIXEL, MODE_PIXEL,
        MODE_PIXEL, MODE_PIXEL, MODE_FLUSH, MODE_PIXEL, MODE_PIXEL,
        MODE_FLUSH, MODE_PIXEL, MODE_PIXEL, MODE_PIXEL, MODE_PIXEL,
        MODE_FLUSH, MODE_PIXEL, MODE_PIXEL, MODE_PIXEL, MODE_PIXEL};
    logic [PIX_W-1:0] dir_pix [DIRECTED_N] = '{
        16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001,
        16'h5555, 16'haaaa, 16'hffff, 16'h7fff, 16'h7fff,
        16'h0000, 16'h8000, 16'h8000, 16'h00ff, 16'hff00,
        16'h1234, 16'h7ffe, 16'h8001, 16'h0100, 16'hfffe};

    neighbor_mean_3x3 u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("neighbor_mean_3x3_tb: errors");
            $finish;
        end
    end

    // both sides sampled at the rising edge, before the block updates
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_word(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_word(m_axis_tdata, m_axis_tlast);
    end

    function automatic t_pace pick_pace();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return PACE_FULL;
        if (r < 8) return PACE_LIGHT;
        return PACE_HEAVY;
    endfunction

    function automatic int draw_gap(t_pace pace);
        case (pace)
            PACE_FULL:  return 0;
            PACE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
            default:    return $urandom_range(0, 16);
        endcase
    endfunction

    function automatic t_fill pick_fill();
        case ($urandom_range(0, 9))
            0:       return FILL_MAX;
            1:       return FILL_MIN;
            2:       return FILL_CHECKER;
            default: return FILL_MIXED;
        endcase
    endfunction

    // uniform three-row bands give interior means at both extremes
    function automatic logic [PIX_W-1:0] frame_pixel(t_fill fill, int row, int col);
        int pick;
        case (fill)
            FILL_MAX:     return PIX_MAX;
            FILL_MIN:     return PIX_MIN;
            FILL_CHECKER: return ((row + col) % 2 == 0) ? PIX_MAX : PIX_MIN;
            default: begin
                pick = $urandom_range(0, 99);
                if (pick < 8)  return PIX_MAX;
                if (pick < 16) return PIX_MIN;
                if (pick < 22) return '0;
                if (pick < 26) return '1;
                if (pick < 30) return PIX_W'(int'($urandom_range(0, 16)) - 8);
                return PIX_W'($urandom);
            end
        endcase
    endfunction

    // called and left at a falling edge; valid stays up between back-to-back words
    task automatic send_word(input logic mode, input logic [PIX_W-1:0] pix);
        int gap;
        if (sent_words % 400 == 0) send_pace = pick_pace();
        gap = draw_gap(send_pace);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent_words++;
        @(negedge i_clk);
    endtask

    // stop offering until every owed mean has come out
    task automatic settle_outputs();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
    endtask

    // raster pixels from position first on, with the odd flush word in between
    task automatic feed_pixels(input int first, input int count);
        int row, col;
        for (int k = first; k < first + count; k++) begin
            row = k / SIDE;
            col = k % SIDE;
            if (col == 0 && row % 3 == 0) row_fill = pick_fill();
            if ($urandom_range(0, 99) == 0)
                send_word(MODE_FLUSH, PIX_W'($urandom));
            else
                send_word(MODE_PIXEL, frame_pixel(row_fill, row, col));
        end
    endtask

    initial begin : stimulus
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_PIXEL;
        i_rst_n       = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // the frame opens with extremes, bit patterns and flush words
        for (int k = 0; k < DIRECTED_N; k++) send_word(dir_mode[k], dir_pix[k]);
        feed_pixels(DIRECTED_N, FIRST_PART);
        settle_outputs();
        feed_pixels(DIRECTED_N + FIRST_PART, SECOND_PART);
        settle_outputs();
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);

        $display("summary: %0d words in (%0d flush), %0d means checked, %0d frame ends",
                 board.words_in, board.flush_words, board.results_seen, board.frame_ends);
        $display("summary: %0d corner, %0d edge, %0d inner means, %0d mismatches",
                 board.corner_hits, board.edge_hits, board.inner_hits, board.errors);
        if (board.errors == 0)
            $display("neighbor_mean_3x3_tb: clean");
        else
            $display("neighbor_mean_3x3_tb: errors");
        $finish;
    end

    // receiver: random gaps per word plus a few long holds that back up the block
    initial begin : result_sink
        int gap;
        int taken;
        int hold_idx;
        m_axis_tready = 1'b0;
        taken    = 0;
        hold_idx = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_idx < HOLDS && board.results_seen >= hold_at[hold_idx]) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_idx++;
            end
            if (taken % 250 == 0) sink_pace = pick_pace();
            gap = draw_gap(sink_pace);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            taken++;
            @(negedge i_clk);
        end
    end

endmodule
